[hw/rtl/lru_block_residency_tracker_defines.svh]
// Assertion macros for the LRU block residency tracker.
// Used by modules that assert; expects clk and rst_n in scope.
`ifndef LRU_BLOCK_RESIDENCY_TRACKER_DEFINES_SVH
`define LRU_BLOCK_RESIDENCY_TRACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBRT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBRT_ASSERT(lbl, prop, msg)
`define LBRT_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/lbrt_pkg.sv]
// Shared types and constants for the LRU block residency tracker.
// No dependencies.
package lbrt_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int TURN_W         = 2;
    localparam int PROTECT_NEWEST = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_BLOCKS = 2'd2;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 11'd16;
    localparam logic [CFG_W-1:0] MIN_CAPACITY   = 11'd5;

    typedef struct packed {
        logic rd_en;
        logic prev_we;
        logic next_we;
        logic res_we;
        logic res_wdata;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_ROOM,
        ST_MV1,
        ST_MV2,
        ST_MV3,
        ST_EVICT,
        ST_INS1,
        ST_INS2,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/lbrt_mem.sv]
// Link and residency storage: prev/next link arrays and resident bits.
// Resident bits are swept to zero after reset. Depends on lbrt_pkg.
module lbrt_mem
    import lbrt_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mem_ctl_t                            ctl,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       rd_addr,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       prev_waddr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     prev_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       next_waddr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     next_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       res_waddr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]     rd_prev,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]     rd_next,
    output logic                                rd_res,
    output logic                                clear_busy
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    logic [LW-1:0] prev_mem [MAX_BLOCKS];
    logic [LW-1:0] next_mem [MAX_BLOCKS];
    logic          res_mem  [MAX_BLOCKS];

    logic [LW-1:0] clr_cnt_reg;
    logic [LW-1:0] clr_cnt_next;
    logic          res_we;
    logic [IW-1:0] res_addr;
    logic          res_data;

    assign clear_busy   = clr_cnt_reg != LW'(MAX_BLOCKS);
    assign clr_cnt_next = clear_busy ? clr_cnt_reg + LW'(1) : clr_cnt_reg;
    assign res_we       = clear_busy | ctl.res_we;
    assign res_addr     = clear_busy ? clr_cnt_reg[IW-1:0] : res_waddr;
    assign res_data     = clear_busy ? 1'b0 : ctl.res_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_prev <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_next <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_addr] <= res_data;
        end
        if (ctl.rd_en)
        begin
            rd_res <= res_mem[rd_addr];
        end
    end

endmodule

[hw/rtl/lbrt_ctrl.sv]
// Sequencer: list pointers, counters and the shared move/evict/insert steps,
// plus the result register. Depends on lbrt_pkg and the defines header.
`include "lru_block_residency_tracker_defines.svh"
module lbrt_ctrl
    import lbrt_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [IDX_W-1:0]                    block_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                evicted_valid,
    output logic [IDX_W-1:0]                    evicted_block,
    output logic [IDX_W-1:0]                    assigned_block,
    output logic                                error,
    input  logic [CFG_W-1:0]                    cfg_capacity,
    input  logic                                cfg_read_only,
    input  logic                                bc_load,
    input  logic [CFG_W-1:0]                    bc_load_val,
    input  logic                                clear_busy,
    output mem_ctl_t                            ctl,
    output logic [$clog2(MAX_BLOCKS)-1:0]       rd_addr,
    output logic [$clog2(MAX_BLOCKS)-1:0]       prev_waddr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]     prev_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]       next_waddr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]     next_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]       res_waddr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     rd_prev,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     rd_next,
    input  logic                                rd_res
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

    state_t state_reg, state_next;

    logic              op_reg, op_next;
    logic [IDX_W-1:0]  bi_reg, bi_next;
    logic [IW-1:0]     mv_reg, mv_next;
    logic [IW-1:0]     ins_reg, ins_next;
    logic              rot_reg, rot_next;
    logic [TURN_W-1:0] turns_reg, turns_next;
    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     tail_reg, tail_next;
    logic [LW-1:0]     count_reg, count_next;
    logic [LW-1:0]     bc_reg, bc_next;

    logic              hit_reg, hit_next;
    logic              evv_reg, evv_next;
    logic [IDX_W-1:0]  evb_reg, evb_next;
    logic [IDX_W-1:0]  asg_reg, asg_next;
    logic              err_reg, err_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_evv_reg, out_evv_next;
    logic [IDX_W-1:0]  out_evb_reg, out_evb_next;
    logic [IDX_W-1:0]  out_asg_reg, out_asg_next;
    logic              out_err_reg, out_err_next;

    logic              accept;
    logic              out_free;
    logic [CFG_W-1:0]  cap_eff;
    logic [LW-1:0]     thr;
    logic              head_nil;
    logic              tail_nil;
    logic              room_full;
    logic              can_rot;
    logic              bi_bad;
    logic              table_full;
    logic              mv_is_tail;
    logic [LW-1:0]     bc_sat;

    assign in_stall   = (state_reg != ST_IDLE) | clear_busy;
    assign accept     = in_valid & ~in_stall;
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign cap_eff    = (cfg_capacity < MIN_CAPACITY) ? MIN_CAPACITY : cfg_capacity;
    assign thr        = (bc_reg >= LW'(PROTECT_NEWEST)) ? bc_reg - LW'(PROTECT_NEWEST) : '0;
    assign head_nil   = head_reg == NIL;
    assign tail_nil   = tail_reg == NIL;
    assign room_full  = (32'(count_reg) >= 32'(cap_eff)) & ~head_nil;
    assign can_rot    = ~cfg_read_only & (head_reg >= thr)
                        & (32'(turns_reg) < PROTECT_NEWEST) & (head_reg != tail_reg);
    assign bi_bad     = (32'(bi_reg) >= 32'(bc_reg)) | (32'(bi_reg) >= MAX_BLOCKS);
    assign table_full = bc_reg == NIL;
    assign mv_is_tail = LW'(mv_reg) == tail_reg;
    assign bc_sat     = (32'(bc_load_val) > MAX_BLOCKS) ? NIL : LW'(bc_load_val);

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign evicted_valid  = out_evv_reg;
    assign evicted_block  = out_evb_reg;
    assign assigned_block = out_asg_reg;
    assign error          = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            count_reg     <= '0;
            bc_reg        <= '0;
            out_valid_reg <= 1'b0;
            rot_reg       <= 1'b0;
            turns_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            bc_reg        <= bc_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
            turns_reg     <= turns_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        bi_reg      <= bi_next;
        mv_reg      <= mv_next;
        ins_reg     <= ins_next;
        hit_reg     <= hit_next;
        evv_reg     <= evv_next;
        evb_reg     <= evb_next;
        asg_reg     <= asg_next;
        err_reg     <= err_next;
        out_hit_reg <= out_hit_next;
        out_evv_reg <= out_evv_next;
        out_evb_reg <= out_evb_next;
        out_asg_reg <= out_asg_next;
        out_err_reg <= out_err_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (op_reg)
                begin
                    state_next = table_full ? ST_DONE : ST_ROOM;
                end
                else
                begin
                    state_next = bi_bad ? ST_DONE : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (rd_res)
                begin
                    state_next = mv_is_tail ? ST_DONE : ST_MV1;
                end
                else
                begin
                    state_next = ST_ROOM;
                end
            end
            ST_ROOM:
            begin
                if (!room_full)
                begin
                    state_next = ST_INS1;
                end
                else if (can_rot)
                begin
                    state_next = ST_MV1;
                end
                else
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_MV1:  state_next = ST_MV2;
            ST_MV2:  state_next = ST_MV3;
            ST_MV3:  state_next = rot_reg ? ST_ROOM : ST_DONE;
            ST_EVICT: state_next = ST_INS1;
            ST_INS1: state_next = ST_INS2;
            ST_INS2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        rd_addr        = '0;
        prev_waddr     = '0;
        prev_wdata     = '0;
        next_waddr     = '0;
        next_wdata     = '0;
        res_waddr      = '0;
        op_next        = op_reg;
        bi_next        = bi_reg;
        mv_next        = mv_reg;
        ins_next       = ins_reg;
        rot_next       = rot_reg;
        turns_next     = turns_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        bc_next        = bc_reg;
        hit_next       = hit_reg;
        evv_next       = evv_reg;
        evb_next       = evb_reg;
        asg_next       = asg_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_hit_next   = out_hit_reg;
        out_evv_next   = out_evv_reg;
        out_evb_next   = out_evb_reg;
        out_asg_next   = out_asg_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op;
                    bi_next    = block_index;
                    rot_next   = 1'b0;
                    turns_next = '0;
                    hit_next   = 1'b0;
                    evv_next   = 1'b0;
                    evb_next   = '0;
                    err_next   = 1'b0;
                end
            end
            ST_DECODE:
            begin
                if (op_reg)
                begin
                    if (table_full)
                    begin
                        err_next = 1'b1;
                        asg_next = '0;
                    end
                    else
                    begin
                        asg_next = IDX_W'(bc_reg);
                        ins_next = bc_reg[IW-1:0];
                    end
                end
                else
                begin
                    asg_next = bi_reg;
                    if (bi_bad)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = IW'(bi_reg);
                        mv_next   = IW'(bi_reg);
                        ins_next  = IW'(bi_reg);
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (rd_res)
                begin
                    hit_next = 1'b1;
                end
            end
            ST_ROOM:
            begin
                if (room_full)
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = head_reg[IW-1:0];
                    if (can_rot)
                    begin
                        mv_next  = head_reg[IW-1:0];
                        rot_next = 1'b1;
                    end
                end
            end
            ST_MV1:
            begin
                // unlink from predecessor, point node back at the old tail
                if (rd_prev != NIL)
                begin
                    ctl.next_we = 1'b1;
                    next_waddr  = rd_prev[IW-1:0];
                    next_wdata  = rd_next;
                end
                else
                begin
                    head_next = rd_next;
                end
                ctl.prev_we = 1'b1;
                prev_waddr  = mv_reg;
                prev_wdata  = tail_reg;
            end
            ST_MV2:
            begin
                if (rd_next != NIL)
                begin
                    ctl.prev_we = 1'b1;
                    prev_waddr  = rd_next[IW-1:0];
                    prev_wdata  = rd_prev;
                end
                ctl.next_we = 1'b1;
                next_waddr  = mv_reg;
                next_wdata  = NIL;
            end
            ST_MV3:
            begin
                if (!tail_nil)
                begin
                    ctl.next_we = 1'b1;
                    next_waddr  = tail_reg[IW-1:0];
                    next_wdata  = LW'(mv_reg);
                end
                else
                begin
                    head_next = LW'(mv_reg);
                end
                tail_next = LW'(mv_reg);
                if (rot_reg)
                begin
                    turns_next = turns_reg + TURN_W'(1);
                end
            end
            ST_EVICT:
            begin
                if (rd_prev != NIL)
                begin
                    ctl.next_we = 1'b1;
                    next_waddr  = rd_prev[IW-1:0];
                    next_wdata  = rd_next;
                end
                else
                begin
                    head_next = rd_next;
                end
                if (rd_next != NIL)
                begin
                    ctl.prev_we = 1'b1;
                    prev_waddr  = rd_next[IW-1:0];
                    prev_wdata  = rd_prev;
                end
                else
                begin
                    tail_next = rd_prev;
                end
                ctl.res_we    = 1'b1;
                ctl.res_wdata = 1'b0;
                res_waddr     = head_reg[IW-1:0];
                if (count_reg != '0)
                begin
                    count_next = count_reg - LW'(1);
                end
                evv_next = 1'b1;
                evb_next = IDX_W'(head_reg);
            end
            ST_INS1:
            begin
                ctl.prev_we   = 1'b1;
                prev_waddr    = ins_reg;
                prev_wdata    = tail_reg;
                ctl.next_we   = 1'b1;
                next_waddr    = ins_reg;
                next_wdata    = NIL;
                ctl.res_we    = 1'b1;
                ctl.res_wdata = 1'b1;
                res_waddr     = ins_reg;
            end
            ST_INS2:
            begin
                if (!tail_nil)
                begin
                    ctl.next_we = 1'b1;
                    next_waddr  = tail_reg[IW-1:0];
                    next_wdata  = LW'(ins_reg);
                end
                else
                begin
                    head_next = LW'(ins_reg);
                end
                tail_next  = LW'(ins_reg);
                count_next = count_reg + LW'(1);
                if (op_reg)
                begin
                    bc_next = bc_reg + LW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_evv_next   = evv_reg;
                    out_evb_next   = evb_reg;
                    out_asg_next   = asg_reg;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase

        if (bc_load)
        begin
            bc_next = bc_sat;
        end
    end

    `LBRT_NEVER(a_head_tail_nil, head_nil != tail_nil, "head and tail disagree on empty list")
    `LBRT_NEVER(a_count_range, count_reg > NIL, "resident count above table size")
    `LBRT_ASSERT(a_evict_nonempty, state_reg == ST_EVICT |-> !head_nil && count_reg != '0, "eviction from empty list")
    `LBRT_ASSERT(a_done_load, state_reg == ST_DONE && out_free |=> out_valid_reg, "result not posted")

endmodule

[hw/rtl/lru_block_residency_tracker.sv]
// LRU block residency tracker, top level: configuration registers and glue.
// The input reopens in the same cycle that the result becomes valid; the
// longest path is a miss at capacity with three protected-head rotations.
// Reset: asynchronous; resident bits are swept to zero after reset, with the
// input stalled meanwhile; configuration writes are taken throughout.
module lru_block_residency_tracker
    import lbrt_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [IDX_W-1:0]     block_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic                 evicted_valid,
    output logic [IDX_W-1:0]     evicted_block,
    output logic [IDX_W-1:0]     assigned_block,
    output logic                 error,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    logic [CFG_W-1:0] capacity_reg, capacity_next;
    logic             read_only_reg, read_only_next;
    logic             bc_load;

    mem_ctl_t         ctl;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    prev_waddr;
    logic [LW-1:0]    prev_wdata;
    logic [IW-1:0]    next_waddr;
    logic [LW-1:0]    next_wdata;
    logic [IW-1:0]    res_waddr;
    logic [LW-1:0]    rd_prev;
    logic [LW-1:0]    rd_next;
    logic             rd_res;
    logic             clear_busy;

    assign bc_load = cfg_we & (cfg_index == REG_STORED_BLOCKS);

    always_comb
    begin
        capacity_next  = capacity_reg;
        read_only_next = read_only_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_CAPACITY)
            begin
                capacity_next = cfg_wdata;
            end
            if (cfg_index == REG_READ_ONLY)
            begin
                read_only_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            read_only_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            read_only_reg <= read_only_next;
        end
    end

    lbrt_mem #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .res_waddr  (res_waddr),
        .rd_prev    (rd_prev),
        .rd_next    (rd_next),
        .rd_res     (rd_res),
        .clear_busy (clear_busy)
    );

    lbrt_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .evicted_valid  (evicted_valid),
        .evicted_block  (evicted_block),
        .assigned_block (assigned_block),
        .error          (error),
        .cfg_capacity   (capacity_reg),
        .cfg_read_only  (read_only_reg),
        .bc_load        (bc_load),
        .bc_load_val    (cfg_wdata),
        .clear_busy     (clear_busy),
        .ctl            (ctl),
        .rd_addr        (rd_addr),
        .prev_waddr     (prev_waddr),
        .prev_wdata     (prev_wdata),
        .next_waddr     (next_waddr),
        .next_wdata     (next_wdata),
        .res_waddr      (res_waddr),
        .rd_prev        (rd_prev),
        .rd_next        (rd_next),
        .rd_res         (rd_res)
    );

endmodule

[verif/tb_lru_block_residency_tracker.sv]
// Testbench for lru_block_residency_tracker: directed and random access/append beats,
// checked against an in-bench LRU list predictor, under random gaps and stalls.
// Depends on lbrt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_lru_block_residency_tracker
    import lbrt_pkg::*;
();

    localparam int NBLK           = MAX_BLOCKS_DEF;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_CYCLES = 200;
    localparam int PRESSURE_AFTER = 80;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_APPEND = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CFG_W-1:0] NIL_LINK = CFG_W'(NBLK);

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] bidx;
    } lru_req_t;

    typedef struct packed {
        logic             hit;
        logic             ev_valid;
        logic [IDX_W-1:0] ev_block;
        logic [IDX_W-1:0] assigned;
        logic             err;
    } lru_result_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 op             = 1'b0;
    logic [IDX_W-1:0]     block_index    = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 hit;
    logic                 evicted_valid;
    logic [IDX_W-1:0]     evicted_block;
    logic [IDX_W-1:0]     assigned_block;
    logic                 error;
    logic                 cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_wdata      = '0;

    lru_block_residency_tracker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .block_index    (block_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .evicted_valid  (evicted_valid),
        .evicted_block  (evicted_block),
        .assigned_block (assigned_block),
        .error          (error),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predictor state
    logic [CFG_W-1:0] prev_m [NBLK];
    logic [CFG_W-1:0] next_m [NBLK];
    bit               res_m  [NBLK];
    logic [CFG_W-1:0] head_m, tail_m, rcount_m, bc_m;
    logic [CFG_W-1:0] cap_m;
    bit               ro_m;

    lru_req_t    pending_q [$];
    lru_result_t lru_expect_q [$];
    int          fail_cnt = 0;

    // generation-side view
    int gen_bc = 0;
    int recent_q [$];

    function automatic void list_reset();
        for (int i = 0; i < NBLK; i++)
        begin
            prev_m[i] = '0;
            next_m[i] = '0;
            res_m[i]  = 1'b0;
        end
        cap_m    = CAPACITY_RESET;
        ro_m     = 1'b0;
        head_m   = NIL_LINK;
        tail_m   = NIL_LINK;
        rcount_m = '0;
        bc_m     = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_CAPACITY:      cap_m = data;
            REG_READ_ONLY:     ro_m = data[0];
            REG_STORED_BLOCKS:
            begin
                bc_m = (data > NBLK) ? NIL_LINK : data;
            end
            default: ;
        endcase
    endfunction

    function automatic void unlink_node(logic [CFG_W-1:0] x);
        logic [CFG_W-1:0] p, n;
        if (x >= NBLK)
            return;
        p = prev_m[x];
        n = next_m[x];
        if (p < NBLK)
            next_m[p] = n;
        else
            head_m = n;
        if (n < NBLK)
            prev_m[n] = p;
        else
            tail_m = p;
    endfunction

    function automatic void link_at_tail(logic [CFG_W-1:0] x);
        if (x >= NBLK)
            return;
        prev_m[x] = tail_m;
        next_m[x] = NIL_LINK;
        if (tail_m < NBLK)
            next_m[tail_m] = x;
        else
            head_m = x;
        tail_m = x;
    endfunction

    // evicts the LRU block when full, rotating protected newest blocks first unless read-only
    function automatic logic [CFG_W-1:0] evict_for_insert();
        logic [CFG_W-1:0] eff_cap, thr, victim;
        int turns;
        eff_cap = (cap_m < MIN_CAPACITY) ? MIN_CAPACITY : cap_m;
        if (rcount_m < eff_cap || head_m >= NBLK)
            return NIL_LINK;
        thr = (bc_m >= PROTECT_NEWEST) ? CFG_W'(bc_m - PROTECT_NEWEST) : '0;
        victim = head_m;
        turns = 0;
        while (!ro_m && victim >= thr && turns < PROTECT_NEWEST && victim != tail_m)
        begin
            unlink_node(victim);
            link_at_tail(victim);
            victim = head_m;
            turns++;
        end
        if (victim >= NBLK)
            return NIL_LINK;
        unlink_node(victim);
        res_m[victim] = 1'b0;
        if (rcount_m > 0)
            rcount_m--;
        return victim;
    endfunction

    function automatic lru_result_t predict_residency(logic req_op, logic [IDX_W-1:0] bidx);
        lru_result_t r;
        logic [CFG_W-1:0] idx, victim;
        r = '0;
        r.assigned = bidx;
        idx = {1'b0, bidx};
        if (req_op == OP_APPEND)
        begin
            if (bc_m >= NBLK)
            begin
                r.err = 1'b1;
                r.assigned = '0;
            end
            else
            begin
                idx = bc_m;
                r.assigned = idx[IDX_W-1:0];
                victim = evict_for_insert();
                if (victim < NBLK)
                begin
                    r.ev_valid = 1'b1;
                    r.ev_block = victim[IDX_W-1:0];
                end
                link_at_tail(idx);
                res_m[idx] = 1'b1;
                rcount_m++;
                bc_m++;
            end
        end
        else if (idx >= bc_m)
            r.err = 1'b1;
        else if (res_m[idx])
        begin
            r.hit = 1'b1;
            if (idx != tail_m)
            begin
                unlink_node(idx);
                link_at_tail(idx);
            end
        end
        else
        begin
            victim = evict_for_insert();
            if (victim < NBLK)
            begin
                r.ev_valid = 1'b1;
                r.ev_block = victim[IDX_W-1:0];
            end
            link_at_tail(idx);
            res_m[idx] = 1'b1;
            rcount_m++;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // driver
    int       gap_left = 0;
    int       calm_in  = 0;
    lru_req_t drv_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= 1'b0;
            block_index <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                lru_expect_q = {lru_expect_q, predict_residency(op, block_index)};
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    drv_req = pending_q.pop_front();
                    op          <= drv_req.op;
                    block_index <= drv_req.bidx;
                    in_valid    <= 1'b1;
                    gap_left = (calm_in > 0) ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
            if (calm_in > 0)
                calm_in--;
            else if ($urandom_range(99) < 2)
                calm_in = 60;
        end
    end

    // monitor
    int          stall_left    = 0;
    int          hold_left     = 0;
    int          calm_out      = 0;
    int          results_seen  = 0;
    bit          pressure_done = 1'b0;
    lru_result_t mon_exp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (lru_expect_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    fail_cnt++;
                end
                else
                begin
                    mon_exp = lru_expect_q.pop_front();
                    if (hit !== mon_exp.hit)
                    begin
                        $error("hit: expected %0d, got %0d", mon_exp.hit, hit);
                        fail_cnt++;
                    end
                    if (evicted_valid !== mon_exp.ev_valid)
                    begin
                        $error("evicted_valid: expected %0d, got %0d",
                               mon_exp.ev_valid, evicted_valid);
                        fail_cnt++;
                    end
                    if (evicted_block !== mon_exp.ev_block)
                    begin
                        $error("evicted_block: expected %0d, got %0d",
                               mon_exp.ev_block, evicted_block);
                        fail_cnt++;
                    end
                    if (assigned_block !== mon_exp.assigned)
                    begin
                        $error("assigned_block: expected %0d, got %0d",
                               mon_exp.assigned, assigned_block);
                        fail_cnt++;
                    end
                    if (error !== mon_exp.err)
                    begin
                        $error("error: expected %0d, got %0d", mon_exp.err, error);
                        fail_cnt++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (results_seen >= PRESSURE_AFTER && !pressure_done)
            begin
                // long hold-off so the tracker backs up onto its input
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm_out == 0 && $urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
            if (calm_out > 0)
                calm_out--;
            else if ($urandom_range(99) == 0)
                calm_out = 80;
        end
    end

    // watchdog: cycles without any beat
    int idle_cnt = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic add_item(logic req_op, int idx);
        lru_req_t it;
        it.op = req_op;
        if (req_op == OP_APPEND)
        begin
            it.bidx = IDX_W'($urandom_range(NBLK - 1));
            if (gen_bc < NBLK)
            begin
                recent_q = {recent_q, gen_bc};
                gen_bc++;
            end
        end
        else
        begin
            it.bidx = IDX_W'(idx);
            recent_q = {recent_q, idx};
        end
        if (recent_q.size() > 8)
            void'(recent_q.pop_front());
        pending_q = {pending_q, it};
    endtask

    task automatic add_mix(int n, int app_pct, int hit_pct, int range_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < app_pct)
                add_item(OP_APPEND, 0);
            else if (r < app_pct + hit_pct && recent_q.size() > 0)
                add_item(OP_ACCESS, recent_q[$urandom_range(recent_q.size() - 1)]);
            else if (r < app_pct + hit_pct + range_pct && gen_bc > 0)
                add_item(OP_ACCESS, $urandom_range(gen_bc - 1));
            else
                add_item(OP_ACCESS, $urandom_range(NBLK - 1));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_q.size() != 0 || in_valid || lru_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        gen_bc = int'(bc_m);
    endtask

    initial
    begin
        list_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // small capacity (below minimum), write mode, empty table
        write_reg(REG_CAPACITY, 11'd0);
        write_reg(REG_READ_ONLY, 11'd0);
        write_reg(REG_STORED_BLOCKS, 11'd0);
        gen_bc = int'(bc_m);
        @(negedge clk);
        add_item(OP_ACCESS, 0);
        repeat (5) add_item(OP_APPEND, 0);
        add_item(OP_ACCESS, 4);
        add_item(OP_ACCESS, 2);
        add_item(OP_APPEND, 0);
        add_item(OP_ACCESS, 0);
        add_item(OP_ACCESS, 1);
        add_item(OP_ACCESS, 5);
        add_item(OP_ACCESS, 0);
        add_item(OP_ACCESS, 1);
        add_item(OP_APPEND, 0);
        add_item(OP_ACCESS, NBLK - 1);
        add_item(OP_ACCESS, 3);
        add_item(OP_APPEND, 0);
        add_item(OP_APPEND, 0);
        add_item(OP_ACCESS, 7);
        wait_idle();

        // write mode, small random capacities
        write_reg(REG_CAPACITY, 11'($urandom_range(12, 1)));
        @(negedge clk);
        add_mix(75, 25, 35, 30);
        wait_idle();
        write_reg(REG_CAPACITY, 11'($urandom_range(12, 5)));
        @(negedge clk);
        add_mix(75, 30, 35, 25);
        wait_idle();

        // read-only use with a larger existing table
        write_reg(REG_READ_ONLY, 11'd1);
        write_reg(REG_CAPACITY, 11'd8);
        write_reg(REG_STORED_BLOCKS, 11'((gen_bc + 200 > NBLK) ? NBLK : gen_bc + 200));
        @(negedge clk);
        add_item(OP_APPEND, 0);
        add_mix(120, 15, 30, 45);
        wait_idle();

        // huge capacity grows residency, then minimum capacity trims it
        write_reg(REG_READ_ONLY, 11'd0);
        write_reg(REG_CAPACITY, 11'h7FF);
        @(negedge clk);
        add_mix(80, 10, 10, 75);
        wait_idle();
        write_reg(REG_CAPACITY, MIN_CAPACITY);
        @(negedge clk);
        add_mix(60, 20, 30, 45);
        wait_idle();

        // full table: stored count saturates to the block limit
        write_reg(REG_UNUSED, 11'h2AA);
        write_reg(REG_CAPACITY, 11'(NBLK));
        write_reg(REG_READ_ONLY, 11'($urandom_range(1)));
        write_reg(REG_STORED_BLOCKS, 11'h7FF);
        @(negedge clk);
        add_item(OP_APPEND, 0);
        add_item(OP_ACCESS, NBLK - 1);
        add_item(OP_ACCESS, 0);
        add_mix(30, 20, 30, 50);
        wait_idle();

        if (lru_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", lru_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
